[src/rgcd_pkg.sv]
// Shared types for the running GCD accumulator.
// Holds the command and status bundles between controller and datapath; no dependencies.
package rgcd_pkg;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;     // an input item is accepted this cycle
      logic step;     // run one binary GCD iteration
      logic finish;   // write the GCD back into the running divisor
   } rgcd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic zero_in;     // the offered number is zero (end of list)
      logic have_value;  // the current list already holds a number
      logic gcd_done;    // one operand of the iteration has reached zero
   } rgcd_sts_type;

endpackage

[src/rgcd_datapath.sv]
// Datapath of the running GCD accumulator: running divisor, binary GCD unit, result register.
// Depends on rgcd_pkg for the command and status bundles.
module rgcd_datapath
   import rgcd_pkg::*;
#(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rgcd_cmd_type          cmd,
   output rgcd_sts_type          sts,
   input  logic [VALUE_BITS-1:0] req_number,
   output logic [VALUE_BITS-1:0] rsp_gcd_value,
   output logic                  rsp_list_empty
);

   localparam int KW = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0] divisor_ff, divisor_in;
   logic                  have_ff, have_in;
   logic [VALUE_BITS-1:0] a_ff, a_in;
   logic [VALUE_BITS-1:0] b_ff, b_in;
   logic [KW-1:0]         k_ff, k_in;
   logic [VALUE_BITS-1:0] gcd_ff, gcd_in;
   logic                  empty_ff, empty_in;

   logic                  zero_in;
   logic [VALUE_BITS:0]   a_minus_b;
   logic [VALUE_BITS-1:0] b_minus_a;
   logic [VALUE_BITS-1:0] gcd_result;

   assign zero_in    = (req_number == '0);
   assign a_minus_b  = {1'b0, a_ff} - {1'b0, b_ff};
   assign b_minus_a  = b_ff - a_ff;
   assign gcd_result = (a_ff | b_ff) << k_ff;

   assign sts.zero_in    = zero_in;
   assign sts.have_value = have_ff;
   assign sts.gcd_done   = (a_ff == '0) || (b_ff == '0);

   // Running divisor and list flag.
   always_comb begin
      divisor_in = divisor_ff;
      have_in    = have_ff;
      gcd_in     = gcd_ff;
      empty_in   = empty_ff;
      if (cmd.take) begin
         if (zero_in) begin
            gcd_in     = have_ff ? divisor_ff : '0;
            empty_in   = ~have_ff;
            divisor_in = '0;
            have_in    = 1'b0;
         end else if (!have_ff) begin
            divisor_in = req_number;
            have_in    = 1'b1;
         end
      end else if (cmd.finish) begin
         divisor_in = gcd_result;
      end
   end

   // Binary GCD iteration: strip common twos, strip lone twos, subtract odd from odd.
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      k_in = k_ff;
      if (cmd.take) begin
         a_in = divisor_ff;
         b_in = req_number;
         k_in = '0;
      end else if (cmd.step) begin
         if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + KW'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (!a_minus_b[VALUE_BITS]) begin
            a_in = {1'b0, a_minus_b[VALUE_BITS-1:1]};
         end else begin
            b_in = {1'b0, b_minus_a[VALUE_BITS-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= '0;
         have_ff    <= 1'b0;
      end else begin
         divisor_ff <= divisor_in;
         have_ff    <= have_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      k_ff     <= k_in;
      gcd_ff   <= gcd_in;
      empty_ff <= empty_in;
   end

   assign rsp_gcd_value  = gcd_ff;
   assign rsp_list_empty = empty_ff;

endmodule

[src/rgcd_controller.sv]
// Controller of the running GCD accumulator: handshakes and GCD iteration sequencing.
// Depends on rgcd_pkg for the command and status bundles.
module rgcd_controller
   import rgcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  rgcd_sts_type sts,
   output rgcd_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;

   // A zero item needs the result register; nonzero items never do.
   assign req_stall = (state_ff != ST_IDLE) || (sts.zero_in && rsp_valid_ff && rsp_stall);
   assign take      = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.take     = take;
      cmd.step     = 1'b0;
      cmd.finish   = 1'b0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (sts.zero_in) begin
                  rsp_valid_in = 1'b1;
               end else if (sts.have_value) begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (sts.gcd_done) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[src/running_gcd_accumulator.sv]
// Running GCD accumulator, top level.
// Joins rgcd_controller and rgcd_datapath; depends on rgcd_pkg.
//
// Usage:
//   req channel: one unsigned number per item. A nonzero number joins the current
//   list, a zero number closes it. rsp channel: one item per closed list, with the
//   list's GCD in rsp_gcd_value, or zero and rsp_list_empty high for an empty list.
// Timing:
//   The first number of a list loads the running divisor. Every later number runs a
//   binary GCD (shift or subtract, one iteration per cycle) against the running
//   divisor; req_stall stays high meanwhile. A zero item's result shows on rsp the
//   next cycle.
// Reset:
//   Synchronous, active high. Clears the running divisor, the list flag, the
//   controller state and rsp_valid.
// Back pressure:
//   The result is held in an output register while rsp_stall is high. Nonzero
//   numbers are still taken during that time; only a zero item waits for the slot.
module running_gcd_accumulator
   import rgcd_pkg::*;
#(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_number,
   // result items
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_gcd_value,
   output logic                  rsp_list_empty
);

   rgcd_cmd_type cmd;   // controller -> datapath
   rgcd_sts_type sts;   // datapath -> controller

   // Sequencing and handshakes.
   rgcd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Running divisor, GCD iteration and result register.
   rgcd_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_number     (req_number),
      .rsp_gcd_value  (rsp_gcd_value),
      .rsp_list_empty (rsp_list_empty)
   );

endmodule
